// ===== sv/fno_pkg.sv =====
// ============================================================================
// fno_pkg
// Shared constants and register codes of the feather normal offset block.
// ============================================================================
package fno_pkg;

    localparam int NORM_FRAC  = 16;
    localparam int DIST_BITS  = 19;
    localparam int NORM_TOP   = 30;
    localparam int SQRT_STEPS = 32;
    localparam int QUOT_BITS  = 18;

    typedef enum logic [1:0] {
        REG_CLOCKWISE = 2'd0,
        REG_DIST_X    = 2'd1,
        REG_DIST_Y    = 2'd2
    } t_reg;

endpackage

// ===== sv/feather_normal_offset.sv =====
// ============================================================================
// feather_normal_offset
// Moves a polygon point along the unit normal of its neighbour chord.
// ============================================================================
// Input stream: one beat per point, carrying the point and its previous and
// next neighbours. Output stream: one beat per input beat, same order, with
// the offset point and a flag in tuser that marks clamping.
// The APB port holds orientation and the two feather distances; write them
// only while no beat is in flight.
// Throughput is one beat per cycle while the output is not stalled. The
// pipeline depth comes from the square root (one result bit per stage,
// 32 stages) and the two dividers (one quotient bit per stage, 18 stages),
// with normalize, square, multiply, round and saturate stages around them.
// Each stage advances when it is empty or its successor advances, so a stall
// at the output fills empty stages first; the input keeps taking beats until
// the pipeline is full.
// Reset clears all valid bits and the configuration registers.
// ============================================================================
module feather_normal_offset #(
    parameter int COORD_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // point_x, point_y, before_x, before_y, after_x, after_y
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // offset_x, offset_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0] o_m_tdata,
    // saturated
    output logic                   o_m_tuser,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int CB  = COORD_BITS;
    localparam int LW  = $clog2(CB + 1);
    localparam int QB  = fno_pkg::QUOT_BITS;
    localparam int DB  = fno_pkg::DIST_BITS;
    localparam int PW  = QB + DB;
    localparam int TW  = PW + 2 - fno_pkg::NORM_FRAC;
    localparam int SW  = ((CB > TW) ? CB : TW) + 1;
    localparam int OW  = ((2*CB+7)/8)*8;

    localparam int ST_LEAD  = 1;
    localparam int ST_SHIFT = 2;
    localparam int ST_SQR   = 3;
    localparam int ST_SUM   = 4;
    localparam int ST_SQRT  = 5;
    localparam int ST_NUM   = ST_SQRT + fno_pkg::SQRT_STEPS;
    localparam int ST_DIV   = ST_NUM + 1;
    localparam int ST_MUL   = ST_DIV + QB;
    localparam int ST_RND   = ST_MUL + 1;
    localparam int ST_SAT   = ST_RND + 1;
    localparam int NST      = ST_SAT + 1;

    typedef struct packed {
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic                 negx;
        logic                 negy;
        logic                 zero;
        logic [CB:0]          mx;
        logic [CB:0]          my;
        logic [LW-1:0]        lead;
        logic [30:0]          nx;
        logic [30:0]          ny;
        logic [61:0]          qsx;
        logic [61:0]          qsy;
        logic [62:0]          s;
        logic [63:0]          r;
        logic [31:0]          n;
        logic [47:0]          rx;
        logic [47:0]          ry;
        logic [QB-1:0]        qx;
        logic [QB-1:0]        qy;
        logic                 sx;
        logic                 sy;
        logic [PW-1:0]        prx;
        logic [PW-1:0]        pry;
        logic signed [TW-1:0] tx;
        logic signed [TW-1:0] ty;
        logic                 sat;
        logic signed [CB-1:0] ox;
        logic signed [CB-1:0] oy;
    } t_item;

    logic                 r_cw;
    logic signed [DB-1:0] r_dx;
    logic signed [DB-1:0] r_dy;

    t_item r_st [NST];
    t_item n_st [NST];
    logic [NST-1:0] r_vld;
    logic [NST-1:0] adv;

    function automatic logic signed [TW-1:0] round_term(
        input logic [PW-1:0] p, input logic neg
    );
        logic [PW:0]   rs;
        logic [TW-2:0] m;
        rs = {1'b0, p} + (PW+1)'(1 << (fno_pkg::NORM_FRAC - 1));
        m  = rs[PW:fno_pkg::NORM_FRAC];
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    function automatic logic signed [CB-1:0] clamp(
        input logic signed [CB-1:0] p, input logic signed [TW-1:0] t, output logic hit
    );
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        sum = SW'(p) + SW'(t);
        hi  = (SW'(1) <<< (CB - 1)) - SW'(1);
        lo  = -hi - SW'(1);
        hit = 1'b0;
        if (sum > hi) begin
            hit = 1'b1;
            sum = hi;
        end else if (sum < lo) begin
            hit = 1'b1;
            sum = lo;
        end
        return sum[CB-1:0];
    endfunction

    function automatic t_item stage_fn(
        input int k, input t_item a, input logic cw,
        input logic signed [DB-1:0] dx, input logic signed [DB-1:0] dy
    );
        t_item          b;
        logic [CB:0]    m;
        logic [CB+31:0] wx;
        logic [CB+31:0] wy;
        logic [63:0]    bitv;
        logic [63:0]    trial;
        logic [49:0]    d;
        logic [QB-1:0]  ax;
        logic [QB-1:0]  ay;
        logic [DB-1:0]  mdx;
        logic [DB-1:0]  mdy;
        logic           hx;
        logic           hy;
        int             j;
        b = a;
        if (k == ST_LEAD) begin
            m = a.mx | a.my;
            b.lead = '0;
            for (int i = 0; i <= CB; i++) begin
                if (m[i]) begin
                    b.lead = LW'(i);
                end
            end
        end else if (k == ST_SHIFT) begin
            wx = (CB+32)'(a.mx);
            wy = (CB+32)'(a.my);
            if (int'(a.lead) < fno_pkg::NORM_TOP) begin
                wx = wx << (fno_pkg::NORM_TOP - int'(a.lead));
                wy = wy << (fno_pkg::NORM_TOP - int'(a.lead));
            end else begin
                wx = wx >> (int'(a.lead) - fno_pkg::NORM_TOP);
                wy = wy >> (int'(a.lead) - fno_pkg::NORM_TOP);
            end
            b.nx = wx[30:0];
            b.ny = wy[30:0];
        end else if (k == ST_SQR) begin
            b.qsx = a.nx * a.nx;
            b.qsy = a.ny * a.ny;
        end else if (k == ST_SUM) begin
            b.s = 63'(a.qsx) + 63'(a.qsy);
            b.r = '0;
        end else if (k >= ST_SQRT && k < ST_NUM) begin
            j     = k - ST_SQRT;
            bitv  = 64'(1) << (62 - 2*j);
            trial = a.r + bitv;
            if (64'(a.s) >= trial) begin
                b.s = a.s - trial[62:0];
                b.r = (a.r >> 1) + bitv;
            end else begin
                b.r = a.r >> 1;
            end
        end else if (k == ST_NUM) begin
            b.n  = a.r[31:0];
            b.rx = (48'(a.ny) << fno_pkg::NORM_FRAC) + 48'(a.r[31:1]);
            b.ry = (48'(a.nx) << fno_pkg::NORM_FRAC) + 48'(a.r[31:1]);
            b.qx = '0;
            b.qy = '0;
        end else if (k >= ST_DIV && k < ST_MUL) begin
            j = QB - 1 - (k - ST_DIV);
            d = 50'(a.n) << j;
            if ({2'b00, a.rx} >= d) begin
                b.rx    = a.rx - d[47:0];
                b.qx[j] = 1'b1;
            end
            if ({2'b00, a.ry} >= d) begin
                b.ry    = a.ry - d[47:0];
                b.qy[j] = 1'b1;
            end
        end else if (k == ST_MUL) begin
            ax  = a.zero ? '0 : a.qx;
            ay  = a.zero ? QB'(1 << fno_pkg::NORM_FRAC) : a.qy;
            mdx = dx[DB-1] ? DB'(-dx) : DB'(dx);
            mdy = dy[DB-1] ? DB'(-dy) : DB'(dy);
            b.prx = PW'(ax) * PW'(mdx);
            b.pry = PW'(ay) * PW'(mdy);
            b.sx  = (a.negx & ~a.zero) ^ dx[DB-1];
            b.sy  = (a.negy & ~a.zero) ^ dy[DB-1];
        end else if (k == ST_RND) begin
            b.tx = round_term(a.prx, a.sx ^ ~cw);
            b.ty = round_term(a.pry, a.sy ^ ~cw);
        end else if (k == ST_SAT) begin
            b.ox  = clamp(a.px, a.tx, hx);
            b.oy  = clamp(a.py, a.ty, hy);
            b.sat = hx | hy;
        end
        return b;
    endfunction

    // chord and its sign and magnitude at the input stage
    always_comb begin
        logic signed [CB:0] cx;
        logic signed [CB:0] cy;
        n_st[0]      = '0;
        n_st[0].px   = i_s_tdata[CB-1:0];
        n_st[0].py   = i_s_tdata[2*CB-1:CB];
        cx = (CB+1)'($signed(i_s_tdata[5*CB-1:4*CB])) - (CB+1)'($signed(i_s_tdata[3*CB-1:2*CB]));
        cy = (CB+1)'($signed(i_s_tdata[6*CB-1:5*CB])) - (CB+1)'($signed(i_s_tdata[4*CB-1:3*CB]));
        n_st[0].negx = (cy > 0);
        n_st[0].negy = cx[CB];
        n_st[0].zero = (cx == '0) && (cy == '0);
        n_st[0].mx   = cx[CB] ? (CB+1)'(-cx) : (CB+1)'(cx);
        n_st[0].my   = cy[CB] ? (CB+1)'(-cy) : (CB+1)'(cy);
        for (int k = 1; k < NST; k++) begin
            n_st[k] = stage_fn(k, r_st[k-1], r_cw, r_dx, r_dy);
        end
    end

    always_comb begin
        adv[NST-1] = ~r_vld[NST-1] | i_m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = ~r_vld[k] | adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (adv[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw <= 1'b0;
            r_dx <= '0;
            r_dy <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                fno_pkg::REG_CLOCKWISE: r_cw <= pwdata[0];
                fno_pkg::REG_DIST_X:    r_dx <= pwdata[DB-1:0];
                fno_pkg::REG_DIST_Y:    r_dy <= pwdata[DB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fno_pkg::REG_CLOCKWISE: prdata = {31'd0, r_cw};
            fno_pkg::REG_DIST_X:    prdata = 32'(r_dx);
            fno_pkg::REG_DIST_Y:    prdata = 32'(r_dy);
            default:                prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign o_s_tready = adv[0];
    assign o_m_tvalid = r_vld[NST-1];
    assign o_m_tdata  = OW'({r_st[NST-1].oy, r_st[NST-1].ox});
    assign o_m_tuser  = r_st[NST-1].sat;

endmodule

// ===== sv/fno_checker.sv =====
// ============================================================================
// fno_checker
// Port-level checks of the feather normal offset block.
// ============================================================================
module fno_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0] o_m_tdata,
    input logic                   o_m_tuser,
    input logic                   pready
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled output beat changed");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input stalled while output drains");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind feather_normal_offset fno_checker #(.COORD_BITS(COORD_BITS)) u_fno_checker (.*);
